/* hw/rtl/cbd_pkg.sv */
// Shared types, codes and character tables for the chunked body decoder.
package cbd_pkg;

    localparam logic [7:0] CHR_CR = 8'h0D;
    localparam logic [7:0] CHR_LF = 8'h0A;
    localparam logic [7:0] CHR_T  = 8'h54;

    localparam logic [4:0] TE_LEN = 5'd26;

    typedef enum logic [2:0] {
        PH_HEADER    = 3'd0,
        PH_SIZE      = 3'd1,
        PH_SIZE_TAIL = 3'd2,
        PH_SIZE_BAD  = 3'd3,
        PH_SIZE_LF   = 3'd4,
        PH_DATA      = 3'd5,
        PH_DATA_CRLF = 3'd6,
        PH_DONE      = 3'd7
    } t_phase;

    typedef enum logic [1:0] {
        K_PAYLOAD = 2'd0,
        K_END     = 2'd1,
        K_NOTCHNK = 2'd2,
        K_BADSIZE = 2'd3
    } t_kind;

    typedef struct packed {
        logic chunked;
        logic blank_done;
    } t_hdr_stat;

    // Characters of "Transfer-Encoding: chunked".
    function automatic logic [7:0] te_char(input logic [4:0] pos);
        logic [7:0] c;
        unique case (pos)
            5'd0:  c = 8'h54;
            5'd1:  c = 8'h72;
            5'd2:  c = 8'h61;
            5'd3:  c = 8'h6E;
            5'd4:  c = 8'h73;
            5'd5:  c = 8'h66;
            5'd6:  c = 8'h65;
            5'd7:  c = 8'h72;
            5'd8:  c = 8'h2D;
            5'd9:  c = 8'h45;
            5'd10: c = 8'h6E;
            5'd11: c = 8'h63;
            5'd12: c = 8'h6F;
            5'd13: c = 8'h64;
            5'd14: c = 8'h69;
            5'd15: c = 8'h6E;
            5'd16: c = 8'h67;
            5'd17: c = 8'h3A;
            5'd18: c = 8'h20;
            5'd19: c = 8'h63;
            5'd20: c = 8'h68;
            5'd21: c = 8'h75;
            5'd22: c = 8'h6E;
            5'd23: c = 8'h6B;
            5'd24: c = 8'h65;
            5'd25: c = 8'h64;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Bit 4 flags a hex digit, bits 3:0 hold its value.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end else begin
            r = 5'd0;
        end
        return r;
    endfunction

endpackage

/* hw/rtl/cbd_hdr_scan.sv */
// Header scanner: chunked transfer text match and blank line detection.
module cbd_hdr_scan (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [7:0]           i_byte,
    output cbd_pkg::t_hdr_stat   o_stat
);
    import cbd_pkg::*;

    logic [4:0] r_pos;
    logic [4:0] n_pos;
    logic       r_chunked;
    logic       n_chunked;
    logic [1:0] r_blank;
    logic [1:0] n_blank;
    logic       w_done;
    logic [7:0] w_blank_chr;

    assign w_blank_chr = r_blank[0] ? CHR_LF : CHR_CR;

    always_comb begin
        n_pos     = r_pos;
        n_chunked = r_chunked;
        if (!r_chunked) begin
            if (i_byte == te_char(r_pos)) begin
                n_pos = r_pos + 5'd1;
            end else begin
                n_pos = (i_byte == CHR_T) ? 5'd1 : 5'd0;
            end
            n_chunked = (n_pos == TE_LEN);
        end
    end

    always_comb begin
        w_done = 1'b0;
        if (i_byte == w_blank_chr) begin
            if (r_blank == 2'd3) begin
                w_done  = 1'b1;
                n_blank = 2'd0;
            end else begin
                n_blank = r_blank + 2'd1;
            end
        end else begin
            n_blank = (i_byte == CHR_CR) ? 2'd1 : 2'd0;
        end
    end

    assign o_stat.chunked    = n_chunked;
    assign o_stat.blank_done = w_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= 5'd0;
            r_chunked <= 1'b0;
            r_blank   <= 2'd0;
        end else if (i_step) begin
            r_pos     <= n_pos;
            r_chunked <= n_chunked;
            r_blank   <= n_blank;
        end
    end

endmodule

/* hw/rtl/chunked_body_decoder_unit.sv */
// Chunked body decoder top level: byte stream in, payload and status beats out.
//
// Input channel (s_axis): one received byte of the request per beat.
// Output channel (m_axis): zero or one beat per input byte. tuser carries the
// kind (payload, body complete, not chunked, bad chunk size), tdata the
// payload byte (zero for status beats), tlast marks the final beat (any
// status beat).
// The header is scanned for the chunked transfer text and the blank line;
// then size lines are parsed, data bytes passed and the CRLF after each chunk
// dropped. After a status beat every further byte is consumed silently.
// An accepted byte is registered in the input register, decoded from there
// and its result registered in the output register that drives m_axis.
// Throughput: one byte per cycle unless m_axis stalls; the decode state
// advances once per byte in a single stage between the input and output
// registers. Reset (synchronous, active low) returns to header scanning and
// empties both registers. When the receiver stalls, the pending result holds
// and the input register keeps one more byte; s_axis tready then drops.
module chunked_body_decoder_unit #(
    parameter int SIZE_BITS = 31
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] in_byte
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic [1:0] o_m_axis_tuser,   // [1:0] kind
    output logic       o_m_axis_tlast
);
    import cbd_pkg::*;

    logic                 r_in_valid;
    logic [7:0]           r_in_byte;
    logic                 w_adv;

    t_phase               r_phase;
    t_phase               n_phase;
    logic [SIZE_BITS-1:0] r_size;
    logic [SIZE_BITS-1:0] n_size;
    logic                 r_hex;
    logic                 n_hex;
    logic [1:0]           r_skip;
    logic [1:0]           n_skip;
    logic [1:0]           w_skip_dec;

    logic                 w_emit;
    t_kind                w_kind;
    logic [7:0]           w_obyte;
    logic [4:0]           w_dig;
    logic                 w_ovf;
    logic                 w_cr;
    t_hdr_stat            w_hdr;

    logic                 r_out_valid;
    logic [7:0]           r_out_byte;
    t_kind                r_out_kind;
    logic                 r_out_last;

    assign w_adv           = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_adv;

    assign w_dig      = hex_value(r_in_byte);
    assign w_ovf      = (r_size[SIZE_BITS-1 -: 4] != 4'd0);
    assign w_cr       = (r_in_byte == CHR_CR);
    assign w_skip_dec = (r_skip != 2'd0) ? r_skip - 2'd1 : r_skip;

    cbd_hdr_scan u_hdr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_adv && (r_phase == PH_HEADER)),
        .i_byte  (r_in_byte),
        .o_stat  (w_hdr)
    );

    // next state
    always_comb begin
        n_phase = r_phase;
        n_size  = r_size;
        n_hex   = r_hex;
        n_skip  = r_skip;
        unique case (r_phase)
            PH_HEADER: begin
                if (w_hdr.blank_done) begin
                    if (!w_hdr.chunked) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_phase = PH_SIZE;
                        n_size  = '0;
                        n_hex   = 1'b0;
                    end
                end
            end
            PH_SIZE, PH_SIZE_TAIL: begin
                if (w_cr) begin
                    if (!r_hex || r_size == '0) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_phase = PH_SIZE_LF;
                    end
                end else if (r_phase == PH_SIZE) begin
                    if (!w_dig[4]) begin
                        n_phase = PH_SIZE_TAIL;
                    end else if (w_ovf) begin
                        n_phase = PH_SIZE_BAD;
                    end else begin
                        n_size = {r_size[SIZE_BITS-5:0], w_dig[3:0]};
                        n_hex  = 1'b1;
                    end
                end
            end
            PH_SIZE_BAD: begin
                if (w_cr) begin
                    n_phase = PH_DONE;
                end
            end
            PH_SIZE_LF: begin
                n_phase = PH_DATA;
            end
            PH_DATA: begin
                n_size = r_size - SIZE_BITS'(1);
                if (r_size == SIZE_BITS'(1)) begin
                    n_phase = PH_DATA_CRLF;
                    n_skip  = 2'd2;
                end
            end
            PH_DATA_CRLF: begin
                n_skip = w_skip_dec;
                if (w_skip_dec == 2'd0) begin
                    n_phase = PH_SIZE;
                    n_size  = '0;
                    n_hex   = 1'b0;
                end
            end
            PH_DONE: begin
                n_phase = r_phase;
            end
        endcase
    end

    // result
    always_comb begin
        w_emit  = 1'b0;
        w_kind  = K_PAYLOAD;
        w_obyte = 8'd0;
        unique case (r_phase)
            PH_HEADER: begin
                if (w_hdr.blank_done && !w_hdr.chunked) begin
                    w_emit = 1'b1;
                    w_kind = K_NOTCHNK;
                end
            end
            PH_SIZE, PH_SIZE_TAIL: begin
                if (w_cr) begin
                    if (!r_hex) begin
                        w_emit = 1'b1;
                        w_kind = K_BADSIZE;
                    end else if (r_size == '0) begin
                        w_emit = 1'b1;
                        w_kind = K_END;
                    end
                end
            end
            PH_SIZE_BAD: begin
                if (w_cr) begin
                    w_emit = 1'b1;
                    w_kind = K_BADSIZE;
                end
            end
            PH_DATA: begin
                w_emit  = 1'b1;
                w_obyte = r_in_byte;
            end
            PH_SIZE_LF, PH_DATA_CRLF, PH_DONE: begin
                w_emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_size  <= '0;
            r_hex   <= 1'b0;
            r_skip  <= 2'd0;
        end else if (w_adv) begin
            r_phase <= n_phase;
            r_size  <= n_size;
            r_hex   <= n_hex;
            r_skip  <= n_skip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_emit;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_emit) begin
            r_out_byte <= w_obyte;
            r_out_kind <= w_kind;
            r_out_last <= (w_kind != K_PAYLOAD);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_byte;
    assign o_m_axis_tuser  = r_out_kind;
    assign o_m_axis_tlast  = r_out_last;

    a_last_on_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_last == (r_out_kind != K_PAYLOAD)))
        else $error("tlast does not match kind");

    a_status_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind != K_PAYLOAD) |-> (r_out_byte == 8'd0))
        else $error("status beat carries data");

    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DONE) |=> (r_phase == PH_DONE))
        else $error("left done phase without reset");

    a_data_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_size != '0))
        else $error("data phase with zero bytes left");

    a_status_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_emit && w_kind != K_PAYLOAD) |=> (r_phase == PH_DONE))
        else $error("status beat without entering done");

endmodule

/* tb/sv/tb_chunked_body_decoder_unit.sv */
`timescale 1ns / 100ps
// Self-checking chunked body decoder testbench: directed bytes, then random chunks or bytes.
module tb_chunked_body_decoder_unit;
    import cbd_pkg::*;

    localparam int SIZE_BITS    = 31;
    localparam int STREAM_BYTES = 1800;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 10;
    localparam logic [8*26-1:0] CHUNKED_TEXT = "Transfer-Encoding: chunked";

    typedef struct packed {
        logic [7:0] data;
        t_kind      kind;
        logic       last;
    } t_dec_result;

    typedef struct {
        logic [7:0]  data;
        bit          typed;
        t_dec_result res;
    } t_stream_beat;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_s_axis_tvalid;
    logic       o_s_axis_tready;
    logic [7:0] i_s_axis_tdata;   // [7:0] in_byte
    logic       o_m_axis_tvalid;
    logic       i_m_axis_tready;
    logic [7:0] o_m_axis_tdata;   // [7:0] out_byte
    logic [1:0] o_m_axis_tuser;   // [1:0] kind
    logic       o_m_axis_tlast;

    t_stream_beat byte_stream[$];
    t_dec_result  expected_q[$];
    t_stream_beat cur_beat;
    t_dec_result  want;
    t_dec_result  pred_res;
    bit           has_res;
    bit           s_took;
    bit           m_took;
    bit           stim_done;
    int           quiet_cycles;
    int           mismatch_count;
    int           idle_pct;
    int           stall_pct;

    t_phase      dec_phase;
    logic [4:0]  te_pos;
    logic        te_found;
    logic [1:0]  blank_pos;
    logic [31:0] size_acc;
    logic        digit_seen;
    logic [1:0]  crlf_left;

    chunked_body_decoder_unit #(
        .SIZE_BITS(SIZE_BITS)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    function automatic bit hex_digit(input logic [7:0] c, output logic [3:0] v);
        v = 4'd0;
        if (c >= "0" && c <= "9") begin
            v = 4'(c - 8'h30);
        end else if (c >= "a" && c <= "f") begin
            v = 4'(c - 8'h57);
        end else if (c >= "A" && c <= "F") begin
            v = 4'(c - 8'h37);
        end else begin
            return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic close_size_line(output bit hit, output t_dec_result res);
        hit = 1'b1;
        res = '0;
        if (!digit_seen) begin
            dec_phase = PH_DONE;
            res = t_dec_result'{8'h00, K_BADSIZE, 1'b1};
        end else if (size_acc == 32'd0) begin
            dec_phase = PH_DONE;
            res = t_dec_result'{8'h00, K_END, 1'b1};
        end else begin
            dec_phase = PH_SIZE_LF;
            hit = 1'b0;
        end
    endtask

    task automatic decode_step(input logic [7:0] c, output bit hit, output t_dec_result res);
        logic [3:0] nib;
        hit = 1'b0;
        res = '0;
        case (dec_phase)
            PH_HEADER: begin
                if (!te_found) begin
                    if (te_pos < TE_LEN && c == CHUNKED_TEXT[8*(25 - int'(te_pos)) +: 8]) begin
                        te_pos = te_pos + 5'd1;
                    end else begin
                        te_pos = (c == CHR_T) ? 5'd1 : 5'd0;
                    end
                    if (te_pos >= TE_LEN) begin
                        te_found = 1'b1;
                    end
                end
                if (c == (blank_pos[0] ? CHR_LF : CHR_CR)) begin
                    if (blank_pos == 2'd3) begin
                        blank_pos = 2'd0;
                        if (!te_found) begin
                            dec_phase = PH_DONE;
                            hit = 1'b1;
                            res = t_dec_result'{8'h00, K_NOTCHNK, 1'b1};
                        end else begin
                            dec_phase = PH_SIZE;
                            size_acc = 32'd0;
                            digit_seen = 1'b0;
                        end
                    end else begin
                        blank_pos = blank_pos + 2'd1;
                    end
                end else begin
                    blank_pos = (c == CHR_CR) ? 2'd1 : 2'd0;
                end
            end
            PH_SIZE: begin
                if (c == CHR_CR) begin
                    close_size_line(hit, res);
                end else if (!hex_digit(c, nib)) begin
                    dec_phase = PH_SIZE_TAIL;
                end else if ((size_acc >> (SIZE_BITS - 4)) != 32'd0) begin
                    dec_phase = PH_SIZE_BAD;
                end else begin
                    size_acc = {size_acc[27:0], nib};
                    digit_seen = 1'b1;
                end
            end
            PH_SIZE_TAIL: begin
                if (c == CHR_CR) begin
                    close_size_line(hit, res);
                end
            end
            PH_SIZE_BAD: begin
                if (c == CHR_CR) begin
                    dec_phase = PH_DONE;
                    hit = 1'b1;
                    res = t_dec_result'{8'h00, K_BADSIZE, 1'b1};
                end
            end
            PH_SIZE_LF: begin
                dec_phase = PH_DATA;
            end
            PH_DATA: begin
                size_acc = size_acc - 32'd1;
                if (size_acc == 32'd0) begin
                    dec_phase = PH_DATA_CRLF;
                    crlf_left = 2'd2;
                end
                hit = 1'b1;
                res = t_dec_result'{c, K_PAYLOAD, 1'b0};
            end
            PH_DATA_CRLF: begin
                if (crlf_left != 2'd0) begin
                    crlf_left = crlf_left - 2'd1;
                end
                if (crlf_left == 2'd0) begin
                    dec_phase = PH_SIZE;
                    size_acc = 32'd0;
                    digit_seen = 1'b0;
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic push_byte(input logic [7:0] b);
        t_stream_beat beat;
        beat.data = b;
        beat.typed = 1'b0;
        beat.res = '0;
        byte_stream.push_back(beat);
    endtask

    task automatic push_typed(input logic [7:0] b, input t_dec_result res);
        t_stream_beat beat;
        beat.data = b;
        beat.typed = 1'b1;
        beat.res = res;
        byte_stream.push_back(beat);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            push_byte(s[i]);
        end
    endtask

    task automatic push_line(input string s);
        push_text(s);
        push_byte(CHR_CR);
        push_byte(CHR_LF);
    endtask

    task automatic push_random(input int count);
        repeat (count) begin
            push_byte(8'($urandom_range(0, 255)));
        end
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] ch;
        ch = (v < 4'd10) ? (8'h30 + 8'(v)) : (8'h57 + 8'(v));
        if (v >= 4'd10 && $urandom_range(0, 1) == 1) begin
            ch = ch - 8'h20;
        end
        return ch;
    endfunction

    function automatic logic [7:0] rand_not_cr();
        logic [7:0] ch;
        do begin
            ch = 8'($urandom_range(0, 255));
        end while (ch == CHR_CR);
        return ch;
    endfunction

    function automatic logic [7:0] rand_non_hex();
        logic [7:0] ch;
        logic [3:0] nib;
        do begin
            ch = 8'($urandom_range(0, 255));
        end while (ch == CHR_CR || hex_digit(ch, nib));
        return ch;
    endfunction

    task automatic push_size_ext();
        push_byte(rand_non_hex());
        repeat ($urandom_range(0, 6)) begin
            push_byte(rand_not_cr());
        end
    endtask

    task automatic push_leading_zeros();
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 4)) begin
                push_byte("0");
            end
        end
    endtask

    task automatic push_size_line(input logic [31:0] size);
        int ndig;
        push_leading_zeros();
        ndig = 1;
        while (ndig < 8 && (size >> (4 * ndig)) != 32'd0) begin
            ndig++;
        end
        for (int i = ndig - 1; i >= 0; i--) begin
            push_byte(hex_char(4'(size >> (4 * i))));
        end
        if ($urandom_range(0, 3) == 0) begin
            push_size_ext();
        end
        push_byte(CHR_CR);
        push_byte(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : CHR_LF);
    endtask

    task automatic push_header_line();
        logic [7:0] ch;
        repeat ($urandom_range(1, 24)) begin
            ch = 8'($urandom_range(0, 255));
            push_byte((ch == CHR_CR || ch == CHR_LF) ? 8'h78 : ch);
        end
        push_byte(CHR_CR);
        push_byte(CHR_LF);
    endtask

    task automatic push_chunk();
        int size;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: size = $urandom_range(1, 16);
            7, 8:                size = $urandom_range(17, 96);
            default:             size = $urandom_range(97, 300);
        endcase
        push_size_line(size);
        push_random(size);
        if ($urandom_range(0, 5) != 0) begin
            push_line("");
        end else begin
            push_random(2);
        end
    endtask

    task automatic push_terminal();
        case ($urandom_range(0, 3))
            0: begin
                repeat ($urandom_range(1, 3)) begin
                    push_byte("0");
                end
                if ($urandom_range(0, 1) == 1) begin
                    push_size_ext();
                end
                push_typed(CHR_CR, t_dec_result'{8'h00, K_END, 1'b1});
            end
            1: begin
                if ($urandom_range(0, 1) == 1) begin
                    push_size_ext();
                end
                push_typed(CHR_CR, t_dec_result'{8'h00, K_BADSIZE, 1'b1});
            end
            2: begin
                push_leading_zeros();
                if ($urandom_range(0, 1) == 1) begin
                    push_text("80000000");
                end else begin
                    push_byte(hex_char(4'($urandom_range(8, 15))));
                    repeat (7 + $urandom_range(0, 3)) begin
                        push_byte(hex_char(4'($urandom_range(0, 15))));
                    end
                end
                if ($urandom_range(0, 1) == 1) begin
                    push_size_ext();
                end
                push_typed(CHR_CR, t_dec_result'{8'h00, K_BADSIZE, 1'b1});
            end
            default: begin
                push_size_line(32'h7FFF_FFFF);
                push_random(300);
                return;
            end
        endcase
        push_byte(CHR_LF);
        push_random(30);
    endtask

    task automatic build_stream();
        repeat ($urandom_range(1, 4)) begin
            push_header_line();
        end
        if ($urandom_range(0, 9) == 0) begin
            push_line("Transfer-Encoding: chunkeD");
            push_line("transfer-encoding: chunked");
            push_line("Transfer-Encoding:chunked");
            push_byte(CHR_CR);
            push_typed(CHR_LF, t_dec_result'{8'h00, K_NOTCHNK, 1'b1});
            push_random(STREAM_BYTES - byte_stream.size());
            return;
        end
        push_line("TrTransfer-Encoding: chunked");
        push_byte(CHR_CR);
        push_line("A");
        push_byte(CHR_CR);
        push_line("");
        push_line("");
        push_line("1");
        push_typed(8'hFF, t_dec_result'{8'hFF, K_PAYLOAD, 1'b0});
        push_line("");
        push_line("01");
        push_typed(8'h00, t_dec_result'{8'h00, K_PAYLOAD, 1'b0});
        push_byte(8'hFF);
        push_byte(CHR_CR);
        push_line("A;f");
        push_random(10);
        push_line("");
        while (byte_stream.size() < STREAM_BYTES) begin
            push_chunk();
        end
        push_terminal();
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin : drive_input
        int n_sent;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = 8'h00;
        stim_done = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        build_stream();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        n_sent = 0;
        while (n_sent < byte_stream.size() || i_s_axis_tvalid) begin
            @(negedge i_clk);
            case (n_sent * 4 / byte_stream.size())
                0: begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct = 48;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct = 0;
                    stall_pct = 48;
                end
                default: begin
                    idle_pct = 6;
                    stall_pct = 6;
                end
            endcase
            if (i_s_axis_tvalid && !s_took) begin
                continue;
            end
            i_s_axis_tvalid = 1'b0;
            if (n_sent < byte_stream.size() && $urandom_range(0, 99) >= idle_pct) begin
                cur_beat = byte_stream[n_sent];
                n_sent++;
                i_s_axis_tdata = cur_beat.data;
                i_s_axis_tvalid = 1'b1;
            end
        end
        stim_done = 1'b1;
    end

    initial begin : drive_ready
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_m_axis_tready = ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_took = 1'b0;
            quiet_cycles = 0;
            dec_phase = PH_HEADER;
            te_pos = 5'd0;
            te_found = 1'b0;
            blank_pos = 2'd0;
            size_acc = 32'd0;
            digit_seen = 1'b0;
            crlf_left = 2'd0;
        end else begin
            s_took = i_s_axis_tvalid && o_s_axis_tready;
            m_took = o_m_axis_tvalid && i_m_axis_tready;
            if (m_took) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: expected no beat, got data=%02h kind=%0d last=%0b",
                             $time, o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast);
                    mismatch_count++;
                end else begin
                    want = expected_q.pop_front();
                    if (o_m_axis_tdata !== want.data || o_m_axis_tuser !== want.kind ||
                        o_m_axis_tlast !== want.last) begin
                        $display({"%0t: expected data=%02h kind=%0d last=%0b, ",
                                  "got data=%02h kind=%0d last=%0b"},
                                 $time, want.data, want.kind, want.last,
                                 o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast);
                        mismatch_count++;
                    end
                end
            end
            if (s_took) begin
                decode_step(cur_beat.data, has_res, pred_res);
                if (cur_beat.typed) begin
                    expected_q.push_back(cur_beat.res);
                end else if (has_res) begin
                    expected_q.push_back(pred_res);
                end
            end
            quiet_cycles = (s_took || m_took) ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin : finish_run
        mismatch_count = 0;
        wait (stim_done);
        while (expected_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
